// ----- rtl/slx_pkg.sv -----
// slx_pkg: shared types and constants for the source lexer
// character item, token record and record bundle layouts, kind and keyword codes
// no dependencies
package slx_pkg;

	// token lengths stop at the lesser of this and 255
	localparam int MAX_TOKEN_LEN = 255;
	localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

	// one character gives at most this many records
	localparam int MAX_REC = 3;

	// depth of the bundle queue between scanner and record output
	localparam int BUN_FIFO_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_STRING  = 3'd1,
		KIND_KEYWORD = 3'd2,
		KIND_IDENT   = 3'd3,
		KIND_SYMBOL  = 3'd4,
		KIND_INVALID = 3'd5,
		KIND_UNTERM  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_OP      = 3'd3,
		MODE_COMMENT = 3'd4
	} mode_t;

	localparam logic [1:0] KW_CODE_FOR   = 2'd0;
	localparam logic [1:0] KW_CODE_WHILE = 2'd1;
	localparam logic [1:0] KW_CODE_IF    = 2'd2;
	localparam logic [1:0] KW_CODE_ELSE  = 2'd3;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] row;
		logic [15:0] col;
		logic        end_of_source;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  symbol_code;
		logic [1:0]  keyword_code;
		logic [15:0] start_row;
		logic [15:0] start_col;
		logic [7:0]  tok_len;
		logic        run_last;
	} tok_rec_t;

	// records caused by one character, in order; the last one has run_last set
	typedef struct packed {
		tok_rec_t [MAX_REC-1:0] recs;
	} bundle_t;

endpackage

// ----- rtl/slx_front.sv -----
// slx_front: character scanner, classifies each character and updates the token state
// produces the bundle of records that one character causes
// depends on slx_pkg
module slx_front import slx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_item_t item,
	output bundle_t  bun,
	output logic     bun_push
);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	// keyword text, first character in the low byte
	localparam logic [39:0] KW_FOR_TEXT   = 40'h0000726f66;
	localparam logic [39:0] KW_WHILE_TEXT = 40'h656c696877;
	localparam logic [39:0] KW_IF_TEXT    = 40'h0000006669;
	localparam logic [39:0] KW_ELSE_TEXT  = 40'h0065736c65;
	localparam logic [7:0]  KW_FOR_LEN    = 8'd3;
	localparam logic [7:0]  KW_WHILE_LEN  = 8'd5;
	localparam logic [7:0]  KW_IF_LEN     = 8'd2;
	localparam logic [7:0]  KW_ELSE_LEN   = 8'd4;
	localparam logic [7:0]  PREFIX_CHARS  = 8'd5;

	typedef struct packed {
		logic       found;
		logic [5:0] code;
	} sym_hit_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
			(c == 8'h24) || (c == 8'h5f);
	endfunction

	function automatic logic is_single_op(input logic [7:0] c);
		logic r;
		case (c)
			8'h2c, 8'h2e, 8'h3b, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_multi_op(input logic [7:0] c);
		logic r;
		case (c)
			8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h21, 8'h3c, 8'h3e, 8'h26, 8'h7c,
			8'h5e: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return !is_space(c) && (c != CH_QUOTE) && (c != CH_HASH) &&
			!is_single_op(c) && !is_multi_op(c);
	endfunction

	// symbol table, text packed first character low, zero padded
	function automatic sym_hit_t sym_lookup(input logic [23:0] v);
		sym_hit_t h;
		h.found = 1'b1;
		unique case (v)
			24'h000023: h.code = 6'd0;
			24'h000022: h.code = 6'd1;
			24'h00002c: h.code = 6'd2;
			24'h00002e: h.code = 6'd3;
			24'h00003b: h.code = 6'd4;
			24'h00002b: h.code = 6'd5;
			24'h00002d: h.code = 6'd6;
			24'h00002a: h.code = 6'd7;
			24'h00002f: h.code = 6'd8;
			24'h00003d: h.code = 6'd9;
			24'h000021: h.code = 6'd10;
			24'h00003c: h.code = 6'd11;
			24'h00003e: h.code = 6'd12;
			24'h000026: h.code = 6'd13;
			24'h00007c: h.code = 6'd14;
			24'h00005e: h.code = 6'd15;
			24'h003c3c: h.code = 6'd16;
			24'h003e3e: h.code = 6'd17;
			24'h003d3d: h.code = 6'd18;
			24'h003d21: h.code = 6'd19;
			24'h003d2b: h.code = 6'd20;
			24'h003d2d: h.code = 6'd21;
			24'h003d2a: h.code = 6'd22;
			24'h003d2f: h.code = 6'd23;
			24'h003d3c: h.code = 6'd24;
			24'h003d3e: h.code = 6'd25;
			24'h003d26: h.code = 6'd26;
			24'h003d7c: h.code = 6'd27;
			24'h003d5e: h.code = 6'd28;
			24'h3d3c3c: h.code = 6'd29;
			24'h3d3e3e: h.code = 6'd30;
			24'h002b2b: h.code = 6'd31;
			24'h002d2d: h.code = 6'd32;
			24'h002626: h.code = 6'd33;
			24'h007c7c: h.code = 6'd34;
			24'h000028: h.code = 6'd35;
			24'h000029: h.code = 6'd36;
			24'h00007b: h.code = 6'd37;
			24'h00007d: h.code = 6'd38;
			24'h00005b: h.code = 6'd39;
			24'h00005d: h.code = 6'd40;
			default: begin
				h.found = 1'b0;
				h.code  = 6'd0;
			end
		endcase
		return h;
	endfunction

	function automatic logic [7:0] bump_len(input logic [7:0] n);
		return (n < LEN_CAP) ? n + 8'd1 : n;
	endfunction

	function automatic tok_rec_t mk_rec(input kind_t k, input logic [5:0] s,
		input logic [1:0] kw, input logic [15:0] r, input logic [15:0] cc,
		input logic [7:0] len);
		tok_rec_t t;
		t.kind         = k;
		t.symbol_code  = s;
		t.keyword_code = kw;
		t.start_row    = r;
		t.start_col    = cc;
		t.tok_len      = len;
		t.run_last     = 1'b0;
		return t;
	endfunction

	function automatic tok_rec_t finish_word(input logic [39:0] pre, input logic [7:0] wl,
		input logic [1:0] cls, input logic [15:0] r, input logic [15:0] cc);
		kind_t      k;
		logic [1:0] kw;
		kw = KW_CODE_FOR;
		if (cls[0]) begin
			k = KIND_NUMBER;
		end else if (wl == KW_FOR_LEN && pre == KW_FOR_TEXT) begin
			k = KIND_KEYWORD;
			kw = KW_CODE_FOR;
		end else if (wl == KW_WHILE_LEN && pre == KW_WHILE_TEXT) begin
			k = KIND_KEYWORD;
			kw = KW_CODE_WHILE;
		end else if (wl == KW_IF_LEN && pre == KW_IF_TEXT) begin
			k = KIND_KEYWORD;
			kw = KW_CODE_IF;
		end else if (wl == KW_ELSE_LEN && pre == KW_ELSE_TEXT) begin
			k = KIND_KEYWORD;
			kw = KW_CODE_ELSE;
		end else if (cls[1]) begin
			k = KIND_IDENT;
		end else begin
			k = KIND_INVALID;
		end
		return mk_rec(k, 6'd0, kw, r, cc, wl);
	endfunction

	// pending operator is always a table entry
	function automatic tok_rec_t flush_rec(input logic [15:0] pend, input logic [15:0] r,
		input logic [15:0] cc);
		sym_hit_t h;
		h = sym_lookup({8'h00, pend});
		return mk_rec(KIND_SYMBOL, h.code, KW_CODE_FOR, r, cc,
			(pend[15:8] != 8'h00) ? 8'd2 : 8'd1);
	endfunction

	// scanner state
	mode_t       mode_q, mode_d;
	logic [15:0] pend_q, pend_d;
	logic [39:0] prefix_q, prefix_d;
	logic [7:0]  wlen_q, wlen_d;
	logic [1:0]  cls_q, cls_d;      // bit0 still a number, bit1 still an identifier
	logic [15:0] trow_q, trow_d;
	logic [15:0] tcol_q, tcol_d;
	logic        bsl_q, bsl_d;
	logic        halt_q, halt_d;

	logic        disp;
	logic        plen2;
	logic [23:0] cand;
	sym_hit_t    hit;
	sym_hit_t    op_hit;
	logic        e1_v, e2_v, e3_v;
	tok_rec_t    e1, e2, e3;
	logic [1:0]  n;
	logic [7:0]  c;

	always_comb begin
		c        = item.ch;
		mode_d   = mode_q;
		pend_d   = pend_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;
		cls_d    = cls_q;
		trow_d   = trow_q;
		tcol_d   = tcol_q;
		bsl_d    = bsl_q;
		halt_d   = halt_q;
		disp     = 1'b0;
		plen2    = pend_q[15:8] != 8'h00;
		cand     = plen2 ? {c, pend_q} : {8'h00, c, pend_q[7:0]};
		hit      = sym_lookup(cand);
		op_hit   = sym_lookup({16'h0000, c});
		e1_v     = 1'b0;
		e2_v     = 1'b0;
		e3_v     = 1'b0;
		e1       = '0;
		e2       = '0;
		e3       = '0;

		if (halt_q) begin
			// dropped until end of source, which restarts the scanner
			if (item.end_of_source) begin
				mode_d   = MODE_IDLE;
				pend_d   = '0;
				prefix_d = '0;
				wlen_d   = '0;
				cls_d    = '0;
				trow_d   = '0;
				tcol_d   = '0;
				bsl_d    = 1'b0;
				halt_d   = 1'b0;
			end
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_NL)
						mode_d = MODE_IDLE;
				end
				MODE_STRING: begin
					wlen_d = bump_len(wlen_q);
					if (bsl_q) begin
						bsl_d = 1'b0;
					end else if (c == CH_BSLASH) begin
						bsl_d = 1'b1;
					end else if (c == CH_QUOTE) begin
						e1_v   = 1'b1;
						e1     = mk_rec(KIND_STRING, 6'd0, KW_CODE_FOR, trow_q, tcol_q, wlen_d);
						mode_d = MODE_IDLE;
						wlen_d = '0;
					end
				end
				MODE_WORD: begin
					if (is_word_char(c)) begin
						if (wlen_q < PREFIX_CHARS)
							prefix_d[{wlen_q[2:0], 3'b000} +: 8] = c;
						wlen_d = bump_len(wlen_q);
						if (!is_digit(c))
							cls_d[0] = 1'b0;
						if (!(is_id_start(c) || is_digit(c)))
							cls_d[1] = 1'b0;
					end else begin
						e1_v   = 1'b1;
						e1     = finish_word(prefix_q, wlen_q, cls_q, trow_q, tcol_q);
						mode_d = MODE_IDLE;
						if (e1.kind == KIND_INVALID)
							halt_d = 1'b1;
						else
							disp = 1'b1;
					end
				end
				MODE_OP: begin
					if (hit.found) begin
						if (!plen2 && (c == CH_LT || c == CH_GT) && pend_q[7:0] == c) begin
							pend_d = {c, pend_q[7:0]};
						end else begin
							e1_v   = 1'b1;
							e1     = mk_rec(KIND_SYMBOL, hit.code, KW_CODE_FOR, trow_q, tcol_q,
								plen2 ? 8'd3 : 8'd2);
							pend_d = '0;
							mode_d = MODE_IDLE;
						end
					end else begin
						e1_v   = 1'b1;
						e1     = flush_rec(pend_q, trow_q, tcol_q);
						pend_d = '0;
						mode_d = MODE_IDLE;
						disp   = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					disp   = 1'b1;
				end
			endcase

			// start of a new token with this character
			if (disp && !is_space(c)) begin
				if (c == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (c == CH_QUOTE) begin
					trow_d = item.row;
					tcol_d = item.col;
					mode_d = MODE_STRING;
					wlen_d = 8'd1;
					bsl_d  = 1'b0;
				end else if (is_single_op(c)) begin
					trow_d = item.row;
					tcol_d = item.col;
					e2_v   = 1'b1;
					e2     = mk_rec(KIND_SYMBOL, op_hit.code, KW_CODE_FOR,
						item.row, item.col, 8'd1);
				end else if (is_multi_op(c)) begin
					trow_d = item.row;
					tcol_d = item.col;
					pend_d = {8'h00, c};
					mode_d = MODE_OP;
				end else begin
					trow_d   = item.row;
					tcol_d   = item.col;
					mode_d   = MODE_WORD;
					wlen_d   = 8'd1;
					prefix_d = {32'h0, c};
					cls_d    = {is_id_start(c), (c > CH_ZERO) && (c <= CH_NINE)};
				end
			end

			if (item.end_of_source) begin
				if (!halt_d) begin
					if (mode_d == MODE_WORD) begin
						e3_v = 1'b1;
						e3   = finish_word(prefix_d, wlen_d, cls_d, trow_d, tcol_d);
					end else if (mode_d == MODE_OP) begin
						e3_v = 1'b1;
						e3   = flush_rec(pend_d, trow_d, tcol_d);
					end else if (mode_d == MODE_STRING) begin
						e3_v = 1'b1;
						e3   = mk_rec(KIND_UNTERM, 6'd0, KW_CODE_FOR, trow_d, tcol_d, wlen_d);
					end
				end
				mode_d   = MODE_IDLE;
				pend_d   = '0;
				prefix_d = '0;
				wlen_d   = '0;
				cls_d    = '0;
				trow_d   = '0;
				tcol_d   = '0;
				bsl_d    = 1'b0;
				halt_d   = 1'b0;
			end
		end

		e1.run_last = !(e2_v || e3_v);
		e2.run_last = !e3_v;
		e3.run_last = 1'b1;

		// pack the records in order
		bun = '0;
		n   = 2'd0;
		if (e1_v) begin
			bun.recs[n] = e1;
			n = n + 2'd1;
		end
		if (e2_v) begin
			bun.recs[n] = e2;
			n = n + 2'd1;
		end
		if (e3_v)
			bun.recs[n] = e3;
		bun_push = take && (e1_v || e2_v || e3_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pend_q   <= '0;
			prefix_q <= '0;
			wlen_q   <= '0;
			cls_q    <= '0;
			trow_q   <= '0;
			tcol_q   <= '0;
			bsl_q    <= 1'b0;
			halt_q   <= 1'b0;
		end else if (take) begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			prefix_q <= prefix_d;
			wlen_q   <= wlen_d;
			cls_q    <= cls_d;
			trow_q   <= trow_d;
			tcol_q   <= tcol_d;
			bsl_q    <= bsl_d;
			halt_q   <= halt_d;
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> !bun_push)
		else $error("record produced while scanner halted");

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.end_of_source |=> mode_q == MODE_IDLE && !halt_q && pend_q == 16'h0000)
		else $error("scanner state not cleared after end of source");

endmodule

// ----- rtl/slx_fifo.sv -----
// slx_fifo: small show-ahead queue of record bundles between scanner and output
// register storage, read data taken from the head entry
// no dependencies
module slx_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + CW'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en)
		else $error("bundle queue written while full");

endmodule

// ----- rtl/slx_back.sv -----
// slx_back: takes bundles from the queue and hands out their records one per cycle while pop keeps the output free
// output register decouples the result side from the queue
// depends on slx_pkg
module slx_back import slx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bundle_t  bun_data,
	input  logic     bun_empty,
	output logic     bun_pop,
	output logic     empty,
	input  logic     pop,
	output tok_rec_t token
);

	bundle_t    bun_q;
	logic       bun_vld_q;
	logic [1:0] idx_q;
	tok_rec_t   out_q;
	logic       out_vld_q;

	tok_rec_t   cur;
	logic       out_free;
	logic       adv;
	logic       bun_done;

	always_comb begin
		cur      = bun_q.recs[idx_q];
		out_free = !out_vld_q || pop;
		adv      = bun_vld_q && out_free;
		bun_done = adv && cur.run_last;
		bun_pop  = (!bun_vld_q || bun_done) && !bun_empty;
	end

	assign empty = !out_vld_q;
	assign token = out_q;

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= cur;
		if (bun_pop)
			bun_q <= bun_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			bun_vld_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (adv)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;

			if (bun_pop) begin
				bun_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (bun_done) begin
				bun_vld_q <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// the third record of a bundle is always its last
	a_third_last: assert property (@(posedge clk) disable iff (!arst_n)
		bun_vld_q && idx_q == 2'd2 |-> bun_q.recs[2].run_last)
		else $error("bundle runs past its last record");

	// a transfer that frees the output with no bundle in the bundle register leaves it empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && out_vld_q && !bun_vld_q |=> !out_vld_q)
		else $error("record appeared without a bundle");

endmodule

// ----- rtl/source_lexer.sv -----
// source_lexer: top level of the character-serial lexical scanner
// scanner front end, bundle queue and record output stage
// depends on slx_pkg, slx_front, slx_fifo, slx_back
//
// One source character enters per cycle while full is low; the scanner
// updates its token state in that cycle and writes the zero to three token
// records the character causes into a bundle queue (BUNDLE_DEPTH entries).
// The output stage hands out one record per cycle from its register while pop
// keeps it free; records pass through the queue and a bundle register on their
// way there, so a character that causes several records makes a burst that the
// queue absorbs; full rises only when the queue holds BUNDLE_DEPTH bundles not
// yet started. run_last marks the last record of a character. After an invalid
// token the block drops characters until the one marked end_of_source, which
// restarts scanning with the next character.
module source_lexer import slx_pkg::*; #(
	parameter int BUNDLE_DEPTH = BUN_FIFO_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t char_item,
	output logic     empty,
	input  logic     pop,
	output tok_rec_t token
);

	logic    take;
	bundle_t wr_bun;
	logic    wr_en;
	bundle_t rd_bun;
	logic    rd_en;
	logic    q_empty;

	assign take = push && !full;

	slx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (char_item),
		.bun      (wr_bun),
		.bun_push (wr_en)
	);

	slx_fifo #(
		.WIDTH ($bits(bundle_t)),
		.DEPTH (BUNDLE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_bun),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (rd_bun),
		.empty   (q_empty)
	);

	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bun_data  (rd_bun),
		.bun_empty (q_empty),
		.bun_pop   (rd_en),
		.empty     (empty),
		.pop       (pop),
		.token     (token)
	);

endmodule
